// ----- hw/rtl/sbct_pkg.sv -----
// ----------------------------------------------------------------------------
// sbct_pkg
// Types and constants for the swept box collision test pipeline.
// ----------------------------------------------------------------------------
package sbct_pkg;

  localparam int unsigned CfgW    = 31;  // configuration register width
  localparam int unsigned GapW    = 36;  // signed face gap width
  localparam int unsigned NumW    = GapW + 16;  // gap magnitude scaled by 1.0
  localparam int unsigned DivSteps = 32;  // quotient bits after the overflow check
  localparam int unsigned InW     = 288;
  localparam int unsigned OutW    = 72;

  localparam logic signed [31:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne   = 32'sh0001_0000;

  typedef enum logic [1:0] {
    CfgBoxSizeX  = 2'd0,
    CfgBoxSizeY  = 2'd1,
    CfgBoxSizeZ  = 2'd2,
    CfgBlockSize = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AxisNone = 2'd0,
    AxisX    = 2'd1,
    AxisY    = 2'd2,
    AxisZ    = 2'd3
  } axis_e;

  // face gaps of one axis with its displacement
  typedef struct packed {
    logic signed [GapW-1:0] gin;
    logic signed [GapW-1:0] gout;
    logic signed [31:0]     d;
  } gap_t;

  // one divider lane: remainder, numerator bits merging into quotient bits
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nq;
    logic [31:0] dv;
    logic        neg;
    logic        ovf;
    logic        dz;
  } lane_t;

  // lanes 2*i and 2*i+1 are entry and exit of axis i
  typedef struct packed {
    lane_t [5:0] ln;
    logic  [2:0] gneg;
  } div_t;

  typedef struct packed {
    logic [2:0][31:0] en;
    logic [2:0][31:0] ex;
    logic [2:0]       gneg;
  } times_t;

  typedef struct packed {
    logic        normal_sign;
    logic [1:0]  normal_axis;
    logic [31:0] exit_time;
    logic [31:0] entry_time;
    logic        hit;
  } result_t;

endpackage

// ----- hw/rtl/swept_box_collision_test.sv -----
// ----------------------------------------------------------------------------
// swept_box_collision_test
// Swept box against fixed cubic block, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel s_axis_*: one item holds the moving box minimum corner, the
// block minimum corner and the displacement of this step. Output channel
// m_axis_*: one result item per input item, in order: hit flag, entry and
// exit fractions, contact axis and normal sign.
// Box extents and the block edge come from the write port (cfg_we_i,
// cfg_idx_i, cfg_data_i); write them only while no item is in flight.
// From acceptance to the result showing on m_axis an item passes one gap
// stage, one divider setup stage, 32 restoring divider steps (one quotient
// bit each, six lanes in parallel), one saturation stage and the output
// register. A new item is taken every cycle unless the full pipeline stalls.
// Each stage holds its item while the next is full and stalled; empty stages
// still fill, so input stays ready until the whole pipeline is occupied.
// Reset clears all valid bits and loads every size register with 1.0.
// ----------------------------------------------------------------------------
module swept_box_collision_test (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [sbct_pkg::CfgW-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // box_min_x, box_min_y, box_min_z, block_min_x, block_min_y,
  // block_min_z, disp_x, disp_y, disp_z (32 bits each)
  input  logic [sbct_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // hit, entry_time[32], exit_time[32], normal_axis[2], normal_sign, 4'b0
  output logic [sbct_pkg::OutW-1:0] m_axis_tdata
);
  import sbct_pkg::*;

  localparam int unsigned NStg = DivSteps + 4;
  localparam int unsigned FixS = DivSteps + 2;
  localparam int unsigned OutS = DivSteps + 3;

  logic [CfgW-1:0] size_q [3];
  logic [CfgW-1:0] blk_size_q;

  logic [NStg-1:0] v_q, v_d, rdy;

  gap_t    [2:0] gap_q, gap_d;
  div_t          div_set;
  div_t          div_q [DivSteps+1];
  div_t          div_d [DivSteps+1];
  times_t        fix_q, fix_d;
  result_t       res_q, res_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q[0]  <= CfgW'(QOne);
      size_q[1]  <= CfgW'(QOne);
      size_q[2]  <= CfgW'(QOne);
      blk_size_q <= CfgW'(QOne);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgBoxSizeX:  size_q[0]  <= cfg_data_i;
        CfgBoxSizeY:  size_q[1]  <= cfg_data_i;
        CfgBoxSizeZ:  size_q[2]  <= cfg_data_i;
        CfgBlockSize: blk_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NStg-1] = !v_q[NStg-1] || m_axis_tready;
    for (int k = NStg-2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < NStg; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[OutS];
  assign m_axis_tdata  = {4'b0, res_q};

  // stage 0: face gaps
  always_comb begin
    logic signed [GapW-1:0] bmin, bmax, kmin, kmax;
    logic signed [31:0]     d;
    for (int i = 0; i < 3; i++) begin
      bmin = GapW'($signed(s_axis_tdata[32*i +: 32]));
      kmin = GapW'($signed(s_axis_tdata[32*(3+i) +: 32]));
      d    = $signed(s_axis_tdata[32*(6+i) +: 32]);
      bmax = bmin + $signed({{(GapW-CfgW){1'b0}}, size_q[i]});
      kmax = kmin + $signed({{(GapW-CfgW){1'b0}}, blk_size_q});
      gap_d[i].d = d;
      if (!d[31] && d != 32'sd0) begin
        gap_d[i].gin  = kmin - bmax;
        gap_d[i].gout = kmax - bmin;
      end else begin
        gap_d[i].gin  = kmax - bmin;
        gap_d[i].gout = kmin - bmax;
      end
    end
  end

  // divider setup: magnitudes, quotient sign, early overflow
  always_comb begin
    logic signed [GapW-1:0] g;
    logic [GapW-1:0]        gm;
    logic [NumW-1:0]        n;
    logic [31:0]            dm;
    logic                   dneg;
    for (int l = 0; l < 6; l++) begin
      g    = (l % 2 == 0) ? gap_q[l/2].gin : gap_q[l/2].gout;
      dneg = gap_q[l/2].d[31];
      dm   = dneg ? 32'(-gap_q[l/2].d) : 32'(gap_q[l/2].d);
      gm   = g[GapW-1] ? GapW'(-g) : GapW'(g);
      n    = {gm, 16'b0};
      div_set.ln[l].rem = 32'(n[NumW-1:32]);
      div_set.ln[l].nq  = n[31:0];
      div_set.ln[l].dv  = dm;
      div_set.ln[l].neg = g[GapW-1] ^ dneg;
      // quotient needs more than 32 bits
      div_set.ln[l].ovf = 32'(n[NumW-1:32]) >= dm;
      div_set.ln[l].dz  = gap_q[l/2].d == 32'sd0;
    end
    for (int i = 0; i < 3; i++) begin
      div_set.gneg[i] = gap_q[i].gin[GapW-1];
    end
  end

  // restoring divider steps, one quotient bit per stage
  always_comb begin
    logic [32:0] t;
    div_d[0] = div_set;
    for (int s = 1; s <= DivSteps; s++) begin
      div_d[s] = div_q[s-1];
      for (int l = 0; l < 6; l++) begin
        t = {div_q[s-1].ln[l].rem, div_q[s-1].ln[l].nq[31]};
        if (t >= {1'b0, div_q[s-1].ln[l].dv}) begin
          div_d[s].ln[l].rem = 32'(t - {1'b0, div_q[s-1].ln[l].dv});
          div_d[s].ln[l].nq  = {div_q[s-1].ln[l].nq[30:0], 1'b1};
        end else begin
          div_d[s].ln[l].rem = t[31:0];
          div_d[s].ln[l].nq  = {div_q[s-1].ln[l].nq[30:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation
  always_comb begin
    lane_t       ln;
    logic [31:0] r;
    fix_d.gneg = div_q[DivSteps].gneg;
    for (int l = 0; l < 6; l++) begin
      ln = div_q[DivSteps].ln[l];
      if (ln.dz) begin
        r = (l % 2 == 0) ? SatMin : SatMax;
      end else if (ln.ovf) begin
        r = ln.neg ? SatMin : SatMax;
      end else if (ln.neg) begin
        r = (ln.nq > 32'h8000_0000) ? SatMin : 32'(-ln.nq);
      end else begin
        r = ln.nq[31] ? SatMax : ln.nq;
      end
      if (l % 2 == 0) fix_d.en[l/2] = r;
      else            fix_d.ex[l/2] = r;
    end
  end

  // combine axes
  always_comb begin
    logic signed [31:0] e0, e1, e2, x0, x1, x2, et, xt;
    logic               all_neg, any_over;
    e0 = $signed(fix_q.en[0]);
    e1 = $signed(fix_q.en[1]);
    e2 = $signed(fix_q.en[2]);
    x0 = $signed(fix_q.ex[0]);
    x1 = $signed(fix_q.ex[1]);
    x2 = $signed(fix_q.ex[2]);
    et = e0;
    if (e1 > et) et = e1;
    if (e2 > et) et = e2;
    xt = x0;
    if (x1 < xt) xt = x1;
    if (x2 < xt) xt = x2;
    all_neg  = e0[31] && e1[31] && e2[31];
    any_over = e0 > QOne || e1 > QOne || e2 > QOne;
    res_d.hit        = !(et > xt || all_neg || any_over);
    res_d.entry_time = et;
    res_d.exit_time  = xt;
    // strictly largest entry picks the face
    if (e0 > e1 && e0 > e2) begin
      res_d.normal_axis = AxisX;
      res_d.normal_sign = !fix_q.gneg[0];
    end else if (e1 > e0 && e1 > e2) begin
      res_d.normal_axis = AxisY;
      res_d.normal_sign = !fix_q.gneg[1];
    end else if (e2 > e0 && e2 > e1) begin
      res_d.normal_axis = AxisZ;
      res_d.normal_sign = !fix_q.gneg[2];
    end else begin
      res_d.normal_axis = AxisNone;
      res_d.normal_sign = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) gap_q <= gap_d;
    for (int s = 0; s <= DivSteps; s++) begin
      if (rdy[s+1]) div_q[s] <= div_d[s];
    end
    if (rdy[FixS]) fix_q <= fix_d;
    if (rdy[OutS]) res_q <= res_d;
  end

endmodule

// ----- verif/tb_swept_box_collision_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swept_box_collision_test
// Self-checking bench for the swept box collision pipeline.
// ----------------------------------------------------------------------------
// Box/block/displacement items are driven from a pending queue. Each accepted
// item is run through a local Q16.16 swept-box predictor, and the expected
// result is queued. Results are compared field by field in order. Sizes are
// rewritten between phases while the pipe is empty. Both sides idle at random.
// One receiver hold-off is long enough to back the pipe up into the input.
// ----------------------------------------------------------------------------
module tb_swept_box_collision_test;
  import sbct_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainWait  = 50;
  localparam int unsigned IdleLimit  = 5000;
  localparam longint      QOneL      = 65536;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;

  logic [InW-1:0]      pending_items[$];
  result_t             expected_hits[$];
  logic [CfgW-1:0]     sizes[4];
  logic                item_taken = 1'b0;
  logic                quiet = 1'b0;
  int                  hold_seq = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  mismatches = 0;
  int                  idle_cycles = 0;

  swept_box_collision_test uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic result_t predict_sweep(input logic [InW-1:0] it);
    longint en[3], ex[3], gin[3];
    longint pmin, pmax, kmin, kmax, d, gout;
    longint et, xt;
    logic all_neg, any_over;
    result_t r;
    for (int i = 0; i < 3; i++) begin
      pmin = longint'($signed(it[32*i +: 32]));
      kmin = longint'($signed(it[32*(3+i) +: 32]));
      d    = longint'($signed(it[32*(6+i) +: 32]));
      pmax = pmin + longint'({33'b0, sizes[i]});
      kmax = kmin + longint'({33'b0, sizes[CfgBlockSize]});
      if (d > 0) begin
        gin[i] = kmin - pmax;
        gout = kmax - pmin;
      end else begin
        gin[i] = kmax - pmin;
        gout = kmin - pmax;
      end
      if (d != 0) begin
        en[i] = sat32((gin[i] * QOneL) / d);
        ex[i] = sat32((gout * QOneL) / d);
      end else begin
        en[i] = -64'sd2147483648;
        ex[i] = 64'sd2147483647;
      end
    end
    et = en[0];
    if (en[1] > et) et = en[1];
    if (en[2] > et) et = en[2];
    xt = ex[0];
    if (ex[1] < xt) xt = ex[1];
    if (ex[2] < xt) xt = ex[2];
    all_neg  = en[0] < 0 && en[1] < 0 && en[2] < 0;
    any_over = en[0] > QOneL || en[1] > QOneL || en[2] > QOneL;
    r.hit = !(et > xt || all_neg || any_over);
    r.entry_time = et[31:0];
    r.exit_time = xt[31:0];
    r.normal_axis = AxisNone;
    r.normal_sign = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (en[i] > en[(i+1)%3] && en[i] > en[(i+2)%3]) begin
        r.normal_axis = axis_e'(i + 1);
        r.normal_sign = !(gin[i] < 0);
        break;
      end
    end
    return r;
  endfunction

  function automatic logic [InW-1:0] mk(input int bx, by, bz, kx, ky, kz, dx, dy, dz);
    return {dz, dy, dx, kz, ky, kx, bz, by, bx};
  endfunction

  // mostly box and block close together with short moves, so hits are common
  function automatic logic [InW-1:0] rand_item();
    logic [InW-1:0] it;
    int base, sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      for (int k = 0; k < 9; k++) it[32*k +: 32] = $urandom;
      return it;
    end
    for (int i = 0; i < 3; i++) begin
      base = $urandom_range(2000000) - 1000000;
      it[32*i +: 32] = base;
      it[32*(3+i) +: 32] = base + int'($urandom_range(400000)) - 200000;
      if ($urandom_range(5) == 0) it[32*(6+i) +: 32] = 0;
      else it[32*(6+i) +: 32] = int'($urandom_range(600000)) - 300000;
    end
    return it;
  endfunction

  task automatic write_size(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sizes[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) pending_items.push_back(rand_item());
    drain();
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || item_taken) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
        s_axis_tdata <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 13);
    end
  end

  // input side: predict on acceptance
  always @(posedge clk_i) begin
    item_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready)
      expected_hits.push_back(predict_sweep(s_axis_tdata));
  end

  // output side: compare
  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[67:0];
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp hit=%0b en=%h ex=%h ax=%0d sg=%0b, ",
                      "got hit=%0b en=%h ex=%h ax=%0d sg=%0b"},
                     want.hit, want.entry_time, want.exit_time, want.normal_axis,
                     want.normal_sign, got.hit, got.entry_time, got.exit_time,
                     got.normal_axis, got.normal_sign);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) sizes[i] = 31'd65536;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset sizes
    pending_items.push_back('0);
    pending_items.push_back({InW{1'b1}});
    pending_items.push_back(mk(0, 0, 0, 131072, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(0, 0, 0, 131072, 0, 0, 131072, 0, 0));      // +x hit
    pending_items.push_back(mk(131072, 0, 0, -65536, 0, 0, -131072, 0, 0)); // -x hit
    pending_items.push_back(mk(0, 0, 0, 0, 131072, 0, 0, 196608, 0));       // +y hit
    pending_items.push_back(mk(0, 0, 0, 0, 0, -131072, 0, 0, -196608));     // -z hit
    pending_items.push_back(mk(0, 0, 0, 131072, 131072, 131072,
                               131072, 131072, 131072));                    // tie
    pending_items.push_back(mk(0, 0, 0, 655360, 0, 0, 65536, 0, 0));        // too far
    pending_items.push_back(mk(0, 0, 0, -327680, 0, 0, 65536, 0, 0));       // moving away
    pending_items.push_back(mk(0, 0, 0, 32768, 0, 0, 65536, 0, 0));         // overlap
    pending_items.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1));
    pending_items.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -1, -1, -1));
    pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0));
    pending_items.push_back(mk(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0,
                               32'h7fff_ffff, 32'h8000_0000, -1));
    drain();
    run_random(100);

    // largest sizes, with a long receiver hold-off against a steady sender
    write_size(CfgBoxSizeX, 31'h7fff_ffff);
    write_size(CfgBoxSizeY, 31'h7fff_ffff);
    write_size(CfgBoxSizeZ, 31'h7fff_ffff);
    write_size(CfgBlockSize, 31'h7fff_ffff);
    quiet = 1'b1;
    hold_seq++;
    run_random(100);
    quiet = 1'b0;

    // zero sizes
    write_size(CfgBoxSizeX, '0);
    write_size(CfgBoxSizeY, '0);
    write_size(CfgBoxSizeZ, '0);
    write_size(CfgBlockSize, '0);
    pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 65536, 65536, 65536));
    run_random(80);

    // mixed and random sizes
    write_size(CfgBoxSizeX, 31'd32768);
    write_size(CfgBoxSizeY, 31'd131072);
    write_size(CfgBoxSizeZ, 31'd65536);
    write_size(CfgBlockSize, 31'd98304);
    run_random(100);
    write_size(CfgBoxSizeX, CfgW'($urandom));
    write_size(CfgBoxSizeY, CfgW'($urandom));
    write_size(CfgBoxSizeZ, CfgW'($urandom));
    write_size(CfgBlockSize, CfgW'($urandom));
    run_random(50);
    write_size(CfgBoxSizeX, CfgW'($urandom_range(200000)));
    write_size(CfgBoxSizeY, CfgW'($urandom_range(200000)));
    write_size(CfgBoxSizeZ, CfgW'($urandom_range(200000)));
    write_size(CfgBlockSize, CfgW'($urandom_range(200000)));
    run_random(60);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
